[sv/peripheral_bus_device_selector_macros.svh]
// Assertion macros shared by the peripheral bus device selector modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PERIPHERAL_BUS_DEVICE_SELECTOR_MACROS_SVH
`define PERIPHERAL_BUS_DEVICE_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBDS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pbds assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pbds assertion failed");

`endif

[sv/pbds_pkg.sv]
// Package for the peripheral bus device selector: sizes, port and opcode
// codes, and the item and result structs. Depends on nothing.
package pbds_pkg;

  localparam int SlotCount = 16;
  localparam int DataWidth = 32;
  localparam int SlotW     = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int StoreW    = (DataWidth < 32) ? DataWidth : 32;

  localparam int InTdataW  = 48;
  localparam int OutTdataW = 56;

  localparam logic [1:0] OpRead   = 2'd0;
  localparam logic [1:0] OpWrite  = 2'd1;
  localparam logic [1:0] OpAttach = 2'd2;

  localparam logic [2:0] PortSelect  = 3'd0;
  localparam logic [2:0] PortModelId = 3'd1;
  localparam logic [2:0] PortCommand = 3'd2;
  localparam logic [2:0] PortA       = 3'd3;
  localparam logic [2:0] PortB       = 3'd4;

  localparam logic [StoreW-1:0] CmdIrqEnable   = StoreW'(1);
  localparam logic [StoreW-1:0] CmdIrqClearAll = StoreW'(2);
  localparam logic [StoreW-1:0] CmdIrqDisable  = StoreW'(3);

  typedef struct packed {
    logic [3:0]  attach_slot;
    logic [31:0] write_data;
    logic [2:0]  port_offset;
    logic [1:0]  opcode;
  } item_t;

  typedef struct packed {
    logic [15:0] irq_enable_mask;
    logic        bus_error;
    logic [31:0] read_data;
  } result_t;

endpackage

[sv/pbds_core.sv]
// Register file and access decode of the peripheral bus device selector.
// Depends on pbds_pkg and the assertion macro header.
`include "peripheral_bus_device_selector_macros.svh"

module pbds_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  pbds_pkg::item_t  item_i,
  output pbds_pkg::result_t result_o
);

  logic [pbds_pkg::SlotW-1:0]     sel_q, sel_d;
  logic [pbds_pkg::SlotCount-1:0] present_q, present_d;
  logic [pbds_pkg::SlotCount-1:0] irq_q, irq_d;
  logic [pbds_pkg::StoreW-1:0]    model_q [pbds_pkg::SlotCount];
  logic [pbds_pkg::StoreW-1:0]    port_a_q [pbds_pkg::SlotCount];
  logic [pbds_pkg::StoreW-1:0]    port_b_q [pbds_pkg::SlotCount];

  logic                           model_we, port_a_we, port_b_we;
  logic [pbds_pkg::SlotW-1:0]     model_idx;
  logic [pbds_pkg::SlotW-1:0]     attach_idx;
  logic [pbds_pkg::StoreW-1:0]    data;
  logic [pbds_pkg::StoreW-1:0]    target;
  logic                           target_ok;
  logic                           attach_ok;
  logic                           present;
  logic [31:0]                    rd;
  logic                           err;

  assign data       = pbds_pkg::StoreW'(item_i.write_data);
  assign present    = present_q[sel_q];
  assign target     = port_b_q[0];
  assign target_ok  = 32'(target) < pbds_pkg::SlotCount;
  assign attach_idx = pbds_pkg::SlotW'(item_i.attach_slot);
  assign attach_ok  = 32'(item_i.attach_slot) < pbds_pkg::SlotCount;

  always_comb begin
    sel_d     = sel_q;
    present_d = present_q;
    irq_d     = irq_q;
    model_we  = 1'b0;
    port_a_we = 1'b0;
    port_b_we = 1'b0;
    model_idx = attach_idx;
    rd        = '0;
    err       = 1'b0;
    case (item_i.opcode)
      pbds_pkg::OpRead: begin
        case (item_i.port_offset)
          pbds_pkg::PortSelect:  rd = 32'(sel_q);
          pbds_pkg::PortModelId: rd = 32'(model_q[sel_q]);
          pbds_pkg::PortCommand: err = !present;
          pbds_pkg::PortA: begin
            if (present) rd = 32'(port_a_q[sel_q]);
            else err = 1'b1;
          end
          pbds_pkg::PortB: begin
            if (present) rd = 32'(port_b_q[sel_q]);
            else err = 1'b1;
          end
          default: err = 1'b1;
        endcase
      end
      pbds_pkg::OpWrite: begin
        case (item_i.port_offset)
          pbds_pkg::PortSelect: begin
            if (32'(data) < pbds_pkg::SlotCount) sel_d = pbds_pkg::SlotW'(data);
            else err = 1'b1;
          end
          pbds_pkg::PortModelId: err = 1'b1;
          pbds_pkg::PortCommand: begin
            if (!present) begin
              err = 1'b1;
            end else if (sel_q == '0) begin
              if (data == pbds_pkg::CmdIrqEnable && target_ok) begin
                irq_d[pbds_pkg::SlotW'(target)] = 1'b1;
              end else if (data == pbds_pkg::CmdIrqClearAll) begin
                irq_d = irq_q & ~(present_q & ~pbds_pkg::SlotCount'(1));
              end else if (data == pbds_pkg::CmdIrqDisable && target_ok) begin
                irq_d[pbds_pkg::SlotW'(target)] = 1'b0;
              end
            end
          end
          pbds_pkg::PortA: begin
            if (present) port_a_we = 1'b1;
            else err = 1'b1;
          end
          pbds_pkg::PortB: begin
            if (present) port_b_we = 1'b1;
            else err = 1'b1;
          end
          default: err = 1'b1;
        endcase
      end
      pbds_pkg::OpAttach: begin
        if (attach_ok) begin
          present_d[attach_idx] = 1'b1;
          model_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign result_o.read_data       = rd;
  assign result_o.bus_error       = err;
  assign result_o.irq_enable_mask = 16'(irq_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= '0;
      present_q <= pbds_pkg::SlotCount'(1);
      irq_q     <= '0;
      for (int i = 0; i < pbds_pkg::SlotCount; i++) begin
        model_q[i]  <= '0;
        port_a_q[i] <= '0;
        port_b_q[i] <= '0;
      end
    end else if (fire_i) begin
      sel_q     <= sel_d;
      present_q <= present_d;
      irq_q     <= irq_d;
      if (model_we) model_q[model_idx] <= data;
      if (port_a_we) port_a_q[sel_q] <= data;
      if (port_b_we) port_b_q[sel_q] <= data;
    end
  end

  `PBDS_ASSERT_NOW(a_ctrl_present, clk_i, rst_ni, 1'b1, present_q[0])
  `PBDS_ASSERT_NOW(a_sel_range, clk_i, rst_ni, 1'b1, 32'(sel_q) < pbds_pkg::SlotCount)
  `PBDS_ASSERT_NEXT(a_attach_sets, clk_i, rst_ni,
                    fire_i && item_i.opcode == pbds_pkg::OpAttach && attach_ok,
                    present_q[$past(attach_idx)])

endmodule

[sv/peripheral_bus_device_selector.sv]
// Peripheral bus device selector: stream front end around the register core.
// Depends on pbds_pkg, pbds_core and the assertion macro header.
//
// Usage: each beat on the slave stream is one bus access (read a port, write
// a port, or attach a device to a slot); each access yields exactly one beat
// on the master stream with the read data, an error flag and the interrupt
// enable mask as it stands after the access.
// The beat is captured in an input register, decoded by short logic against
// the slot registers, and the result lands in an output register. Master
// valid rises once the result is loaded into the output register, which
// follows the input register; throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result waits in the output register and the
// input register still holds one further beat; after that, tready drops until
// the master side drains. State is updated only when a beat leaves the input
// register, so stalls never reorder or repeat accesses.
// Reset selects the controller slot, marks only the controller present and
// clears model ids, port values and interrupt enables; both streams go idle.
`include "peripheral_bus_device_selector_macros.svh"

module peripheral_bus_device_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // opcode[1:0], port_offset[4:2], write_data[36:5], attach_slot[40:37]
  input  logic [pbds_pkg::InTdataW-1:0]    s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // read_data[31:0], bus_error[32], irq_enable_mask[48:33]
  output logic [pbds_pkg::OutTdataW-1:0]   m_axis_tdata_o
);

  logic              in_vld_q;
  pbds_pkg::item_t   in_q;
  logic              out_vld_q;
  pbds_pkg::result_t out_q;
  pbds_pkg::result_t res;
  logic              adv;

  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= pbds_pkg::item_t'(s_axis_tdata_i[$bits(pbds_pkg::item_t)-1:0]);
    end
  end

  pbds_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (adv),
    .item_i   (in_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= res;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = pbds_pkg::OutTdataW'(out_q);

  `PBDS_ASSERT_NOW(a_full_stall, clk_i, rst_ni,
                   in_vld_q && out_vld_q && !m_axis_tready_i, !s_axis_tready_o)
  `PBDS_ASSERT_NEXT(a_adv_loads, clk_i, rst_ni, adv, out_vld_q)
  `PBDS_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni,
                    s_axis_tvalid_i && s_axis_tready_o, in_vld_q)

endmodule
